/* rtl/core/mmcrc_pkg.sv */
package mmcrc_pkg;

  localparam int unsigned CRC_W     = 64;
  localparam int unsigned CRC32_W   = 32;
  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned MODE_W    = 2;
  localparam int unsigned CFG_IDX_W = 1;

  localparam logic [CRC_W-1:0]   POLY64 = 64'h42F0_E1EB_A9EA_3693;
  localparam logic [CRC32_W-1:0] POLY32 = 32'hEDB8_8320;

  localparam logic [BYTE_W-1:0] UPPER_FIRST = 8'h41;
  localparam logic [BYTE_W-1:0] UPPER_LAST  = 8'h5A;
  localparam logic [BYTE_W-1:0] CASE_BIT    = 8'h20;

  localparam logic [MODE_W-1:0] MODE_CRC64      = 2'd0;
  localparam logic [MODE_W-1:0] MODE_CRC64_FOLD = 2'd1;
  localparam logic [MODE_W-1:0] MODE_CRC32      = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_IDX_MODE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SEED = 1'b1;

  typedef logic [CRC_W-1:0]   crc64_t;
  typedef logic [CRC32_W-1:0] crc32_t;
  typedef logic [BYTE_W-1:0]  byte_t;
  typedef logic [MODE_W-1:0]  mode_t;

  // MSB-first byte update
  function automatic crc64_t step64(input crc64_t crc_in, input byte_t data);
    crc64_t c;
    c = crc_in ^ {data, {(CRC_W-BYTE_W){1'b0}}};
    for (int b = 0; b < BYTE_W; b++) begin
      c = c[CRC_W-1] ? ((c << 1) ^ POLY64) : (c << 1);
    end
    return c;
  endfunction

  // reflected byte update
  function automatic crc32_t step32(input crc32_t crc_in, input byte_t data);
    crc32_t c;
    c = crc_in ^ {{(CRC32_W-BYTE_W){1'b0}}, data};
    for (int b = 0; b < BYTE_W; b++) begin
      c = c[0] ? ((c >> 1) ^ POLY32) : (c >> 1);
    end
    return c;
  endfunction

endpackage

/* rtl/core/mmcrc_if.sv */
interface mmcrc_in_if;
  logic                  valid;
  logic                  ready;
  mmcrc_pkg::byte_t      data_byte;
  logic                  has_byte;
  logic                  first_item;
  logic                  last_item;

  modport source (output valid, output data_byte, output has_byte,
                  output first_item, output last_item, input ready);
  modport sink   (input valid, input data_byte, input has_byte,
                  input first_item, input last_item, output ready);
endinterface

interface mmcrc_out_if;
  logic                  valid;
  logic                  ready;
  mmcrc_pkg::crc64_t     crc_result;

  modport source (output valid, output crc_result, input ready);
  modport sink   (input valid, input crc_result, output ready);
endinterface

interface mmcrc_cfg_if;
  logic                                  valid;
  logic                                  ready;
  logic [mmcrc_pkg::CFG_IDX_W-1:0]       index;
  logic [mmcrc_pkg::CRC_W-1:0]           data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

/* rtl/core/multi_mode_crc_engine.sv */
// channel  dir  payload                                        handshake
// in_if    in   data_byte, has_byte, first_item, last_item     valid/ready
// out_if   out  crc_result                                     valid/ready
// cfg_if   in   index (0 crc_mode, 1 seed_value), data         valid/ready
//
// One item per cycle while no last item is stalled; from input accept the result
// passes the input register, byte update logic and result register. Throughput is
// set by the running CRC register, updated once per item.
// rst_n is synchronous, active low; clears mode, seed and running CRC.
// A last item waits in the input register only while the result register is
// full and not taken; other items pass regardless of output stalls.
module multi_mode_crc_engine (
  input  logic clk,
  input  logic rst_n,
  mmcrc_in_if.sink    in_if,
  mmcrc_out_if.source out_if,
  mmcrc_cfg_if.sink   cfg_if
);

  mmcrc_pkg::mode_t  mode_r;
  mmcrc_pkg::crc64_t seed_r;
  mmcrc_pkg::crc64_t crc_r, crc_nxt;

  logic              s1_valid_r;
  mmcrc_pkg::byte_t  s1_byte_r;
  logic              s1_has_r, s1_first_r, s1_last_r;

  logic              out_valid_r;
  mmcrc_pkg::crc64_t out_crc_r, out_crc_nxt;

  logic              out_free, s1_go, c32;
  mmcrc_pkg::crc64_t base, upd;
  mmcrc_pkg::byte_t  byte_in;

  assign cfg_if.ready  = 1'b1;
  assign out_free      = !out_valid_r || out_if.ready;
  assign s1_go         = s1_valid_r && (!s1_last_r || out_free);
  assign in_if.ready   = !s1_valid_r || s1_go;
  assign out_if.valid      = out_valid_r;
  assign out_if.crc_result = out_crc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= mmcrc_pkg::MODE_CRC64;
      seed_r <= '0;
    end else if (cfg_if.valid) begin
      case (cfg_if.index)
        mmcrc_pkg::CFG_IDX_MODE: mode_r <= cfg_if.data[mmcrc_pkg::MODE_W-1:0];
        mmcrc_pkg::CFG_IDX_SEED: seed_r <= cfg_if.data;
        default: ;
      endcase
    end
  end

  always_comb begin
    c32     = mode_r[1];
    byte_in = s1_byte_r;
    if (mode_r == mmcrc_pkg::MODE_CRC64_FOLD &&
        (s1_byte_r inside {[mmcrc_pkg::UPPER_FIRST:mmcrc_pkg::UPPER_LAST]})) begin
      byte_in = s1_byte_r | mmcrc_pkg::CASE_BIT;
    end
    if (s1_first_r) begin
      base = c32 ? {{mmcrc_pkg::CRC32_W{1'b0}}, ~seed_r[mmcrc_pkg::CRC32_W-1:0]} : seed_r;
    end else begin
      base = crc_r;
    end
    if (!s1_has_r) begin
      upd = base;
    end else if (c32) begin
      upd = {{mmcrc_pkg::CRC32_W{1'b0}},
             mmcrc_pkg::step32(base[mmcrc_pkg::CRC32_W-1:0], s1_byte_r)};
    end else begin
      upd = mmcrc_pkg::step64(base, byte_in);
    end
    if (s1_last_r && c32) begin
      crc_nxt     = {{mmcrc_pkg::CRC32_W{1'b0}}, upd[mmcrc_pkg::CRC32_W-1:0]};
      out_crc_nxt = {{mmcrc_pkg::CRC32_W{1'b0}}, ~upd[mmcrc_pkg::CRC32_W-1:0]};
    end else begin
      crc_nxt     = upd;
      out_crc_nxt = upd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      crc_r       <= '0;
    end else begin
      if (in_if.ready) begin
        s1_valid_r <= in_if.valid;
      end
      if (s1_go) begin
        crc_r <= crc_nxt;
      end
      if (s1_go && s1_last_r) begin
        out_valid_r <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_if.valid && in_if.ready) begin
      s1_byte_r  <= in_if.data_byte;
      s1_has_r   <= in_if.has_byte;
      s1_first_r <= in_if.first_item;
      s1_last_r  <= in_if.last_item;
    end
    if (s1_go && s1_last_r) begin
      out_crc_r <= out_crc_nxt;
    end
  end

  a_last_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && s1_last_r && out_valid_r && !out_if.ready) |-> !in_if.ready)
    else $error("input taken while a last item is stalled");

  a_last_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_go && s1_last_r) |=> out_valid_r)
    else $error("last item did not load the result register");

  a_crc32_upper_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_go && s1_last_r && mode_r[1]) |=>
      (out_crc_r[mmcrc_pkg::CRC_W-1:mmcrc_pkg::CRC32_W] == '0))
    else $error("crc32 result has nonzero upper half");

  a_stalled_item_kept: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !s1_go) |=> s1_valid_r)
    else $error("stalled item dropped from input register");

endmodule
